@@ rtl/dshc_pkg.sv @@
// ----------------------------------------------------------------------------
// dshc_pkg: shared types for the digital sensor history check
// Holds the request and response layouts, the history entry layout, the
// result of one entry check, and the sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dshc_pkg;

    // Default number of entries in the history ring.
    localparam int HISTORY_DEPTH_DEF = 128;

    // Request type codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // One request transfer.
    typedef struct packed {
        logic        req_type;
        logic [7:0]  sample_bits;
        logic [31:0] now_ms;
        logic [2:0]  sensor_index;
        logic [31:0] window_ms;
        logic        want_value;
        logic [7:0]  min_count;
    } req_item_t;

    // One response transfer.
    typedef struct packed {
        logic       had_value;
        logic [7:0] match_count;
        logic [7:0] current_bits;
    } rsp_item_t;

    // One history ring entry.
    typedef struct packed {
        logic [7:0]  levels;
        logic [31:0] stamp;
    } hist_entry_t;

    // Outcome of checking one entry against the query.
    typedef struct packed {
        logic in_window;
        logic hit;
    } eval_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/dshc_hist_mem.sv @@
// ----------------------------------------------------------------------------
// dshc_hist_mem: history ring storage
// Single write port and one registered read port. A fill count tracks which
// entries have been written since reset; unwritten entries read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dshc_hist_mem
    import dshc_pkg::*;
#(
    parameter int DEPTH = HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int FW = $clog2(DEPTH + 1)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [AW-1:0] wr_addr,
    input  hist_entry_t wr_data,
    input  logic        rd_en,
    input  logic [AW-1:0] rd_addr,
    output hist_entry_t rd_data
);

    hist_entry_t mem [DEPTH];
    hist_entry_t mem_q_reg;
    logic        written_reg;
    logic        written_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;

    // Pushes fill the ring starting at entry 1, so after n pushes entries
    // 1 through n hold data until the ring has wrapped once.
    always_comb
    begin
        written_next = (fill_reg == FW'(DEPTH)) ||
                       ((rd_addr != '0) && (FW'(rd_addr) <= fill_reg));
        fill_next = fill_reg;
        if (wr_en && (fill_reg != FW'(DEPTH)))
        begin
            fill_next = fill_reg + FW'(1);
        end
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Storage array with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg   <= mem[rd_addr];
            written_reg <= written_next;
        end
    end

    assign rd_data = written_reg ? mem_q_reg : '0;

endmodule

@@ rtl/dshc_check_unit.sv @@
// ----------------------------------------------------------------------------
// dshc_check_unit: entry check
// Computes the wrapped age of one history entry, compares it with the
// window, and tests the chosen sensor level against the wanted value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dshc_check_unit
    import dshc_pkg::*;
(
    input  hist_entry_t entry,
    input  logic [31:0] now_ms,
    input  logic [31:0] window_ms,
    input  logic [2:0]  sensor_index,
    input  logic        want_value,
    output eval_t       result
);

    logic [31:0] age;

    // Age wraps modulo 2^32 by the natural width of the subtraction.
    always_comb
    begin
        age              = now_ms - entry.stamp;
        result.in_window = (age <= window_ms);
        result.hit       = (entry.levels[sensor_index] == want_value);
    end

endmodule

@@ rtl/digital_sensor_history_check_core.sv @@
// ----------------------------------------------------------------------------
// digital_sensor_history_check_core: sensor levels with a timestamped history
// A sample, or a query with a zero minimum, goes to the finish state, which
// loads the response once any earlier one is taken. A query reads one ring
// entry per cycle until it stops on an entry out of the window, on reaching
// the minimum count or after the whole ring. One request is in work at a
// time; the next transfer can come in the cycle after the response is loaded.
// Reset sets all levels high; a fill count makes unwritten entries read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module digital_sensor_history_check_core
    import dshc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    state_t        state_reg, state_next;
    logic [7:0]    current_reg, current_next;
    logic [AW-1:0] newest_reg, newest_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [FW-1:0] issue_cnt_reg, issue_cnt_next;
    logic          data_valid_reg, data_valid_next;
    logic [7:0]    count_reg, count_next;
    logic          is_query_reg, is_query_next;
    logic [31:0]   now_reg, now_next;
    logic [31:0]   window_reg, window_next;
    logic [2:0]    sensor_reg, sensor_next;
    logic          want_reg, want_next;
    logic [7:0]    min_reg, min_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_item_t     rsp_reg, rsp_next;

    logic          accept;
    logic [AW-1:0] push_addr;
    logic          wr_en;
    hist_entry_t   wr_data;
    logic          rd_en;
    hist_entry_t   rd_data;
    eval_t         eval;
    logic          eval_stop;
    logic [8:0]    count_inc;
    logic [7:0]    sample_rev;

    // History ring storage.
    dshc_hist_mem #(
        .DEPTH (HISTORY_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (push_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    // Entry check on the word read in the previous cycle.
    dshc_check_unit u_check (
        .entry        (rd_data),
        .now_ms       (now_reg),
        .window_ms    (window_reg),
        .sensor_index (sensor_reg),
        .want_value   (want_reg),
        .result       (eval)
    );

    // Sample byte holds sensor i at bit 7-i; flip it to sensor i at bit i.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            sample_rev[i] = req.sample_bits[7-i];
        end
    end

    // Ring write position for a push.
    assign push_addr = (newest_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : newest_reg + AW'(1);

    assign accept  = req_valid && req_ready;
    assign wr_en   = accept && (req.req_type == REQ_SAMPLE);
    assign wr_data = '{levels: current_reg, stamp: req.now_ms};

    // Walk control: stop on an entry out of the window, on reaching the minimum
    // count or once every entry is read; otherwise keep one read in flight per cycle.
    always_comb
    begin
        count_inc = {1'b0, count_reg} + 9'd1;
        eval_stop = data_valid_reg &&
                    (!eval.in_window || (eval.hit && (count_inc >= {1'b0, min_reg})));
        rd_en     = (state_reg == ST_WALK) && !eval_stop &&
                    (issue_cnt_reg != FW'(HISTORY_DEPTH));
    end

    // Sequencer next state and datapath updates.
    always_comb
    begin
        state_next      = state_reg;
        current_next    = current_reg;
        newest_next     = newest_reg;
        rd_addr_next    = rd_addr_reg;
        issue_cnt_next  = issue_cnt_reg;
        data_valid_next = rd_en;
        count_next      = count_reg;
        is_query_next   = is_query_reg;
        now_next        = now_reg;
        window_next     = window_reg;
        sensor_next     = sensor_reg;
        want_next       = want_reg;
        min_next        = min_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        req_ready       = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    count_next     = '0;
                    is_query_next  = (req.req_type == REQ_QUERY);
                    now_next       = req.now_ms;
                    window_next    = req.window_ms;
                    sensor_next    = req.sensor_index;
                    want_next      = req.want_value;
                    min_next       = req.min_count;
                    rd_addr_next   = newest_reg;
                    issue_cnt_next = '0;
                    if (req.req_type == REQ_SAMPLE)
                    begin
                        newest_next  = push_addr;
                        current_next = sample_rev;
                        state_next   = ST_FINISH;
                    end
                    else if (req.min_count == 8'd0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (data_valid_reg && eval.in_window && eval.hit)
                begin
                    count_next = count_inc[7:0];
                end
                if (rd_en)
                begin
                    rd_addr_next   = (rd_addr_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                                         : rd_addr_reg - AW'(1);
                    issue_cnt_next = issue_cnt_reg + FW'(1);
                end
                if (eval_stop ||
                    (!data_valid_reg && (issue_cnt_reg == FW'(HISTORY_DEPTH))))
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.had_value   = is_query_reg && (count_reg >= min_reg);
                    rsp_next.match_count = count_reg;
                    rsp_next.current_bits = current_reg;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            current_reg    <= 8'hFF;
            newest_reg     <= '0;
            issue_cnt_reg  <= '0;
            data_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            current_reg    <= current_next;
            newest_reg     <= newest_next;
            issue_cnt_reg  <= issue_cnt_next;
            data_valid_reg <= data_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        count_reg    <= count_next;
        is_query_reg <= is_query_next;
        now_reg      <= now_next;
        window_reg   <= window_next;
        sensor_reg   <= sensor_next;
        want_reg     <= want_next;
        min_reg      <= min_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
